/* src/dhs_pkg.sv */
// Package for the direct-mapped hash store: sizes, job record, back-end state type.
// Used by every module of the block; depends on nothing.
`default_nettype none
package dhs_pkg;

   localparam int TABLE_SLOTS   = 256;
   localparam int VALUE_BITS    = 64;
   localparam int KEY_BITS      = 64;
   localparam int BYTE_BITS     = 8;
   localparam int SLOT_OUT_BITS = 8;
   localparam int CSR_DATA_BITS = 9;
   localparam int SLOT_BITS     = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int DIV_BITS      = $clog2(TABLE_SLOTS + 1);

   // Remainder unit: key bits retired per cycle, and how many such passes one key needs.
   localparam int DIV_STEPS  = 8;
   localparam int DIV_CYCLES = KEY_BITS / DIV_STEPS;
   localparam int CNT_BITS   = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_DATA_BITS-1:0] SLOTS_RESET = CSR_DATA_BITS'(256);

   typedef enum logic {
      CSR_HASH_MODE = 1'b0,
      CSR_SLOTS     = 1'b1
   } csr_index_type;

   typedef enum logic {
      MODE_STRING = 1'b0,
      MODE_WORD   = 1'b1
   } hash_mode_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_DIV,
      B_ACCESS,
      B_RESP
   } back_state_type;

   // One complete request, handed from the front end to the back end.
   typedef struct packed {
      logic                  is_read;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
      logic [DIV_BITS-1:0]   divisor;
   } dhs_job_type;

endpackage : dhs_pkg
`default_nettype wire

/* src/direct_mapped_hash_store.sv */
// Top level of the direct-mapped hash store: configuration registers and wiring.
// Depends on dhs_pkg, dhs_front, dhs_queue and dhs_back.
//
// An item is taken when start is high and busy is low. In word mode every item
// is a request; in string mode each nonzero key byte is folded into the hash in
// the front end and gives no result, and a zero byte completes the request.
// Complete requests wait in a two-entry queue; busy is high while it is full.
// The back end handles one request at a time: it takes it, runs the remainder
// unit (8 key bits per cycle over the 64-bit key), accesses the store and then
// gives the result. The result is shown for exactly one cycle with rsp_valid
// and cannot be held off, so it must be captured then. The store reads as all
// zero after reset at once, with no clearing pass. Configuration is to be
// written only while no request is outstanding; the block does not check this.
`default_nettype none
module direct_mapped_hash_store
   import dhs_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic                     req_type,
   input  wire logic [7:0]               req_key_byte,
   input  wire logic [63:0]              req_key_word,
   input  wire logic [63:0]              req_write_value,
   output logic                          rsp_valid,
   output logic [7:0]                    rsp_slot_index,
   output logic [63:0]                   rsp_read_value,
   output logic                          rsp_was_read,
   input  wire logic                     csr_we,
   input  wire logic                     csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   logic                     hash_mode_ff;
   logic [CSR_DATA_BITS-1:0] slots_ff;
   logic                     accept;
   logic                     push;
   dhs_job_type              push_job;
   dhs_job_type              head_job;
   logic                     q_not_empty;
   logic                     q_full;
   logic                     job_take;

   assign busy   = q_full;
   assign accept = start && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_mode_ff <= MODE_STRING;
         slots_ff     <= SLOTS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HASH_MODE: hash_mode_ff <= csr_wdata[0];
            CSR_SLOTS:     slots_ff     <= csr_wdata;
            default:       hash_mode_ff <= hash_mode_ff;
         endcase
      end
   end

   dhs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .hash_mode       (hash_mode_ff),
      .slots_in_use    (slots_ff),
      .req_type        (req_type),
      .req_key_byte    (req_key_byte),
      .req_key_word    (req_key_word),
      .req_write_value (req_write_value),
      .push            (push),
      .job             (push_job)
   );

   dhs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (job_take),
      .head_job  (head_job),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   dhs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_ready      (q_not_empty),
      .job            (head_job),
      .job_take       (job_take),
      .rsp_valid      (rsp_valid),
      .rsp_slot_index (rsp_slot_index),
      .rsp_read_value (rsp_read_value),
      .rsp_was_read   (rsp_was_read)
   );

endmodule : direct_mapped_hash_store
`default_nettype wire

/* src/dhs_front.sv */
// Front end: takes items, runs the string hash and forms complete requests.
// Depends on dhs_pkg.
`default_nettype none
module dhs_front
   import dhs_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     accept,
   input  wire logic                     hash_mode,
   input  wire logic [CSR_DATA_BITS-1:0] slots_in_use,
   input  wire logic                     req_type,
   input  wire logic [BYTE_BITS-1:0]     req_key_byte,
   input  wire logic [KEY_BITS-1:0]      req_key_word,
   input  wire logic [63:0]              req_write_value,
   output logic                          push,
   output dhs_job_type                   job
);

   logic [KEY_BITS-1:0] hash_ff;
   logic [KEY_BITS-1:0] hash_in;
   logic [DIV_BITS-1:0] divisor;
   logic                byte_zero;

   assign byte_zero = (req_key_byte == '0);

   // Zero selects one slot; anything past the table size saturates to it.
   always_comb begin
      if (slots_in_use == '0) begin
         divisor = DIV_BITS'(1);
      end else if (32'(slots_in_use) > TABLE_SLOTS) begin
         divisor = DIV_BITS'(TABLE_SLOTS);
      end else begin
         divisor = DIV_BITS'(slots_in_use);
      end
   end

   always_comb begin
      hash_in = hash_ff;
      push    = 1'b0;
      if (accept) begin
         if (hash_mode == MODE_WORD) begin
            push = 1'b1;
         end else if (!byte_zero) begin
            // hash * 97 + byte, with 97 = 64 + 32 + 1
            hash_in = (hash_ff << 6) + (hash_ff << 5) + hash_ff + KEY_BITS'(req_key_byte);
         end else begin
            push    = 1'b1;
            hash_in = '0;
         end
      end
   end

   always_comb begin
      job.is_read = req_type;
      job.key     = (hash_mode == MODE_WORD) ? req_key_word : hash_ff;
      job.value   = VALUE_BITS'(req_write_value);
      job.divisor = divisor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= '0;
      end else begin
         hash_ff <= hash_in;
      end
   end

endmodule : dhs_front
`default_nettype wire

/* src/dhs_queue.sv */
// Short request queue between the front end and the back end.
// Depends on dhs_pkg.
`default_nettype none
module dhs_queue
   import dhs_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  push,
   input  wire dhs_job_type push_job,
   input  wire logic  pop,
   output dhs_job_type head_job,
   output logic       not_empty,
   output logic       full
);

   dhs_job_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   head_ff;
   logic [QPTR_BITS-1:0]   head_in;
   logic [QPTR_BITS-1:0]   tail_ff;
   logic [QPTR_BITS-1:0]   tail_in;
   logic [QCNT_BITS-1:0]   count_ff;
   logic [QCNT_BITS-1:0]   count_in;
   logic                   do_push;
   logic                   do_pop;

   assign not_empty = (count_ff != '0);
   assign full      = (32'(count_ff) == QUEUE_DEPTH);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head_job  = entry_ff[head_ff];

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      if (do_pop) begin
         head_in = (32'(head_ff) == QUEUE_DEPTH - 1) ? '0 : head_ff + 1'b1;
      end
      if (do_push) begin
         tail_in = (32'(tail_ff) == QUEUE_DEPTH - 1) ? '0 : tail_ff + 1'b1;
      end
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[tail_ff] <= push_job;
      end
   end

endmodule : dhs_queue
`default_nettype wire

/* src/dhs_back.sv */
// Back end: remainder unit, slot store and result strobe.
// Depends on dhs_pkg.
`default_nettype none
module dhs_back
   import dhs_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      job_ready,
   input  wire dhs_job_type               job,
   output logic                           job_take,
   output logic                           rsp_valid,
   output logic [SLOT_OUT_BITS-1:0]       rsp_slot_index,
   output logic [63:0]                    rsp_read_value,
   output logic                           rsp_was_read
);

   back_state_type         state_ff;
   back_state_type         state_in;
   logic [KEY_BITS-1:0]    dvd_ff;
   logic [KEY_BITS-1:0]    dvd_in;
   logic [SLOT_BITS-1:0]   rem_ff;
   logic [SLOT_BITS-1:0]   rem_in;
   logic [CNT_BITS-1:0]    cnt_ff;
   logic [DIV_BITS-1:0]    div_ff;
   logic                   read_ff;
   logic [VALUE_BITS-1:0]  wval_ff;
   logic [VALUE_BITS-1:0]  rdata_ff;
   logic                   rvalid_ff;
   logic [TABLE_SLOTS-1:0] valid_ff;
   logic [VALUE_BITS-1:0]  mem [TABLE_SLOTS];
   logic                   div_run;
   logic                   div_last;
   logic                   do_access;
   logic [VALUE_BITS-1:0]  slot_value;

   assign div_last = (32'(cnt_ff) == DIV_CYCLES - 1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (job_ready) begin
               state_in = B_DIV;
            end
         end
         B_DIV: begin
            if (div_last) begin
               state_in = B_ACCESS;
            end
         end
         B_ACCESS: begin
            state_in = B_RESP;
         end
         B_RESP: begin
            state_in = B_IDLE;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // Control outputs.
   always_comb begin
      job_take  = 1'b0;
      div_run   = 1'b0;
      do_access = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         B_IDLE:   job_take  = job_ready;
         B_DIV:    div_run   = 1'b1;
         B_ACCESS: do_access = 1'b1;
         B_RESP:   rsp_valid = 1'b1;
         default:  job_take  = 1'b0;
      endcase
   end

   // Restoring remainder, several key bits per cycle. The partial remainder
   // stays below the divisor, so one compare and subtract per bit suffices.
   always_comb begin
      logic [SLOT_BITS:0]    trial;
      logic [SLOT_BITS-1:0]  r;
      logic [KEY_BITS-1:0]   d;
      r = rem_ff;
      d = dvd_ff;
      for (int i = 0; i < DIV_STEPS; i++) begin
         trial = {r, d[KEY_BITS-1]};
         d     = d << 1;
         if (trial >= (SLOT_BITS + 1)'(div_ff)) begin
            r = SLOT_BITS'(trial - (SLOT_BITS + 1)'(div_ff));
         end else begin
            r = SLOT_BITS'(trial);
         end
      end
      rem_in = r;
      dvd_in = d;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_take) begin
         dvd_ff  <= job.key;
         rem_ff  <= '0;
         cnt_ff  <= '0;
         div_ff  <= job.divisor;
         read_ff <= job.is_read;
         wval_ff <= job.value;
      end else if (div_run) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // Slot store. A slot never written since reset reads as zero.
   always_ff @(posedge clock) begin
      if (do_access) begin
         if (read_ff) begin
            rdata_ff <= mem[rem_ff];
         end else begin
            mem[rem_ff] <= wval_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else if (do_access) begin
         rvalid_ff <= valid_ff[rem_ff];
         if (!read_ff) begin
            valid_ff[rem_ff] <= 1'b1;
         end
      end
   end

   always_comb begin
      if (!read_ff) begin
         slot_value = wval_ff;
      end else if (rvalid_ff) begin
         slot_value = rdata_ff;
      end else begin
         slot_value = '0;
      end
   end

   assign rsp_slot_index = SLOT_OUT_BITS'(rem_ff);
   assign rsp_read_value = 64'(slot_value);
   assign rsp_was_read   = read_ff;

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DIV || state_ff == B_ACCESS) |-> (DIV_BITS'(rem_ff) < div_ff))
      else $error("partial remainder reached the divisor");

   a_take_starts_div: assert property (@(posedge clock) disable iff (reset)
      job_take |=> (state_ff == B_DIV && cnt_ff == '0))
      else $error("taken request did not start the remainder unit");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_strobe_after_access: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(do_access))
      else $error("result given without a store access");

   a_write_marks_valid: assert property (@(posedge clock) disable iff (reset)
      (do_access && !read_ff) |=> valid_ff[$past(rem_ff)])
      else $error("written slot not marked valid");

endmodule : dhs_back
`default_nettype wire
